// ===== rtl/sha1bsh_pkg.sv =====
// shared types and constants of the sha-1 byte stream hasher
package sha1bsh_pkg;

  typedef enum logic [1:0] {
    MODE_DATA    = 2'd0,
    MODE_FINISH  = 2'd1,
    MODE_RESTART = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_FOLD,
    S_EMIT
  } state_e;

  typedef enum logic [2:0] {
    PAD_NONE,
    PAD_FIRST,
    PAD_ZERO,
    PAD_LEN,
    PAD_DONE
  } pad_e;

  typedef logic [4:0][31:0] chain_t;

  localparam chain_t CHAIN_INIT = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;
  localparam logic [5:0] LAST_FILL  = 6'd63;
  localparam logic [6:0] LAST_ROUND = 7'd79;
  localparam logic [2:0] LAST_WORD  = 3'd4;

endpackage

// ===== rtl/sha1_byte_stream_hasher.sv =====
// sha-1 byte stream hasher: byte buffer, round sequencer and digest output
// a data word is absorbed into the block buffer; the word that fills a block starts 80 rounds and a fold
// a finish word is accepted, then its pad bytes (9 to 72) are absorbed, and each of the one
// or two blocks it closes goes through the rounds and the fold, then five output words, one per cycle
// when the sink is ready; no new input word is taken until the block or the digest is done
// reset (asynchronous, active low) loads the initial chain and clears fill and byte total
module sha1_byte_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic        last_word_o
);

  sha1bsh_pkg::state_e state_q, state_d;
  sha1bsh_pkg::pad_e   pad_q, pad_d;
  sha1bsh_pkg::chain_t chain_q, chain_d;

  logic [511:0] msg_q, msg_d;
  logic [5:0]   fill_q, fill_d;
  logic [28:0]  total_q, total_d;
  logic [31:0]  len_q, len_d;
  logic [6:0]   rnd_q, rnd_d;
  logic [2:0]   idx_q, idx_d;
  logic [31:0]  a_q, b_q, c_q, d_q, e_q;
  logic [31:0]  a_d, b_d, c_d, d_d, e_d;

  logic        in_acc;
  logic        out_acc;
  logic        abs_en;
  logic [7:0]  abs_byte;
  logic        len_zone;
  logic [7:0]  pad_byte;
  logic [7:0]  len_byte;
  logic [31:0] w_cur, w_new, f_val, k_val, t_val;

  function automatic logic [31:0] w_new_pre(input logic [511:0] m);
    logic [31:0] x;
    x = m[95:64] ^ m[255:224] ^ m[447:416] ^ m[511:480];
    return {x[30:0], x[31]};
  endfunction

  assign in_ready_o    = (state_q == sha1bsh_pkg::S_IDLE);
  assign in_acc        = in_valid_i && in_ready_o;
  assign out_valid_o   = (state_q == sha1bsh_pkg::S_EMIT);
  assign out_acc       = out_valid_o && out_ready_i;
  assign digest_word_o = chain_q[idx_q];
  assign last_word_o   = (idx_q == sha1bsh_pkg::LAST_WORD);

  // padding byte generator
  assign len_zone = (pad_q == sha1bsh_pkg::PAD_LEN) ||
                    ((pad_q == sha1bsh_pkg::PAD_ZERO) && (fill_q == sha1bsh_pkg::LEN_OFFSET));

  always_comb begin
    case (fill_q[1:0])
      2'd0:    len_byte = len_q[31:24];
      2'd1:    len_byte = len_q[23:16];
      2'd2:    len_byte = len_q[15:8];
      default: len_byte = len_q[7:0];
    endcase
  end

  always_comb begin
    if (pad_q == sha1bsh_pkg::PAD_FIRST) begin
      pad_byte = sha1bsh_pkg::PAD_BYTE;
    end else if (len_zone && fill_q[2]) begin
      pad_byte = len_byte;
    end else begin
      pad_byte = 8'h00;
    end
  end

  // round unit
  assign w_cur = msg_q[511:480];
  assign w_new = {w_new_pre(msg_q)};

  always_comb begin
    if (rnd_q < 7'd20) begin
      f_val = (b_q & c_q) | (~b_q & d_q);
      k_val = sha1bsh_pkg::K0;
    end else if (rnd_q < 7'd40) begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = sha1bsh_pkg::K1;
    end else if (rnd_q < 7'd60) begin
      f_val = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
      k_val = sha1bsh_pkg::K2;
    end else begin
      f_val = b_q ^ c_q ^ d_q;
      k_val = sha1bsh_pkg::K3;
    end
  end

  assign t_val = {a_q[26:0], a_q[31:27]} + f_val + e_q + k_val + w_cur;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sha1bsh_pkg::S_IDLE: begin
        if (in_acc) begin
          case (mode_i)
            sha1bsh_pkg::MODE_DATA: begin
              if (fill_q == sha1bsh_pkg::LAST_FILL) state_d = sha1bsh_pkg::S_ROUND;
            end
            sha1bsh_pkg::MODE_FINISH: state_d = sha1bsh_pkg::S_PAD;
            default: state_d = sha1bsh_pkg::S_IDLE;
          endcase
        end
      end
      sha1bsh_pkg::S_PAD: begin
        if (fill_q == sha1bsh_pkg::LAST_FILL) state_d = sha1bsh_pkg::S_ROUND;
      end
      sha1bsh_pkg::S_ROUND: begin
        if (rnd_q == sha1bsh_pkg::LAST_ROUND) state_d = sha1bsh_pkg::S_FOLD;
      end
      sha1bsh_pkg::S_FOLD: begin
        if (pad_q == sha1bsh_pkg::PAD_NONE) begin
          state_d = sha1bsh_pkg::S_IDLE;
        end else if (pad_q == sha1bsh_pkg::PAD_DONE) begin
          state_d = sha1bsh_pkg::S_EMIT;
        end else begin
          state_d = sha1bsh_pkg::S_PAD;
        end
      end
      sha1bsh_pkg::S_EMIT: begin
        if (out_acc && last_word_o) state_d = sha1bsh_pkg::S_IDLE;
      end
      default: state_d = sha1bsh_pkg::S_IDLE;
    endcase
  end

  // datapath and counters
  always_comb begin
    msg_d   = msg_q;
    fill_d  = fill_q;
    total_d = total_q;
    len_d   = len_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    pad_d   = pad_q;
    chain_d = chain_q;
    a_d = a_q;
    b_d = b_q;
    c_d = c_q;
    d_d = d_q;
    e_d = e_q;
    abs_en   = 1'b0;
    abs_byte = data_byte_i;

    case (state_q)
      sha1bsh_pkg::S_IDLE: begin
        if (in_acc) begin
          case (mode_i)
            sha1bsh_pkg::MODE_DATA: abs_en = 1'b1;
            sha1bsh_pkg::MODE_FINISH: begin
              len_d = {total_q, 3'b000};
              pad_d = sha1bsh_pkg::PAD_FIRST;
              idx_d = 3'd0;
            end
            sha1bsh_pkg::MODE_RESTART: begin
              chain_d = sha1bsh_pkg::CHAIN_INIT;
              fill_d  = 6'd0;
              total_d = 29'd0;
            end
            default: ;
          endcase
        end
      end
      sha1bsh_pkg::S_PAD: begin
        abs_en   = 1'b1;
        abs_byte = pad_byte;
        if (pad_q == sha1bsh_pkg::PAD_FIRST) begin
          pad_d = sha1bsh_pkg::PAD_ZERO;
        end else if (len_zone) begin
          pad_d = (fill_q == sha1bsh_pkg::LAST_FILL) ? sha1bsh_pkg::PAD_DONE
                                                     : sha1bsh_pkg::PAD_LEN;
        end
      end
      sha1bsh_pkg::S_ROUND: begin
        msg_d = {msg_q[479:0], w_new};
        a_d   = t_val;
        b_d   = a_q;
        c_d   = {b_q[1:0], b_q[31:2]};
        d_d   = c_q;
        e_d   = d_q;
        rnd_d = rnd_q + 7'd1;
      end
      sha1bsh_pkg::S_FOLD: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        chain_d[4] = chain_q[4] + e_q;
      end
      sha1bsh_pkg::S_EMIT: begin
        if (out_acc) begin
          if (last_word_o) begin
            idx_d = 3'd0;
            pad_d = sha1bsh_pkg::PAD_NONE;
          end else begin
            idx_d = idx_q + 3'd1;
          end
        end
      end
      default: ;
    endcase

    if (abs_en) begin
      msg_d   = {msg_q[503:0], abs_byte};
      fill_d  = fill_q + 6'd1;
      total_d = total_q + 29'd1;
      if (fill_q == sha1bsh_pkg::LAST_FILL) begin
        a_d   = chain_q[0];
        b_d   = chain_q[1];
        c_d   = chain_q[2];
        d_d   = chain_q[3];
        e_d   = chain_q[4];
        rnd_d = 7'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sha1bsh_pkg::S_IDLE;
      pad_q   <= sha1bsh_pkg::PAD_NONE;
      chain_q <= sha1bsh_pkg::CHAIN_INIT;
      fill_q  <= 6'd0;
      total_q <= 29'd0;
      rnd_q   <= 7'd0;
      idx_q   <= 3'd0;
    end else begin
      state_q <= state_d;
      pad_q   <= pad_d;
      chain_q <= chain_d;
      fill_q  <= fill_d;
      total_q <= total_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    msg_q <= msg_d;
    len_q <= len_d;
    a_q   <= a_d;
    b_q   <= b_d;
    c_q   <= c_d;
    d_q   <= d_d;
    e_q   <= e_d;
  end

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("input ready while digest words pending");

  a_round_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1bsh_pkg::S_ROUND) |=>
      (state_q == sha1bsh_pkg::S_ROUND) || (state_q == sha1bsh_pkg::S_FOLD))
    else $error("round sequence left early");

  a_fold_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sha1bsh_pkg::S_FOLD) |-> (rnd_q == 7'd80))
    else $error("fold without 80 rounds");

  a_emit_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_word_o) |=> (state_q == sha1bsh_pkg::S_IDLE) && (fill_q == 6'd0))
    else $error("digest end with block not empty");

endmodule

// ===== dv/tb_sha1_byte_stream_hasher.sv =====
// testbench for the sha-1 byte stream hasher: random and directed words, digest check
`timescale 1ns / 100ps

module tb_sha1_byte_stream_hasher;

  typedef struct {
    sha1bsh_pkg::mode_e mode;
    logic [7:0]         data;
  } in_word_t;

  typedef struct {
    logic [31:0] word;
    logic        last;
  } digest_exp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i = sha1bsh_pkg::MODE_DATA;
  logic [7:0]  data_byte_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic        last_word_o;

  in_word_t    word_q[$];
  digest_exp_t digest_q[$];
  digest_exp_t got_exp;
  in_word_t    next_word;

  logic [7:0]          blk_mem [64];
  logic [5:0]          fill_idx;
  logic [28:0]         byte_cnt;
  sha1bsh_pkg::chain_t chain;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          pressure_on = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;
  int          mismatch_cnt = 0;

  sha1_byte_stream_hasher u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .data_byte_i  (data_byte_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .digest_word_o(digest_word_o),
    .last_word_o  (last_word_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic void sha1_compress();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t;
    int i;
    for (i = 0; i < 16; i++) begin
      w[i] = {blk_mem[4*i], blk_mem[4*i+1], blk_mem[4*i+2], blk_mem[4*i+3]};
    end
    for (i = 16; i < 80; i++) begin
      t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {t[30:0], t[31]};
    end
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    e = chain[4];
    for (i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = sha1bsh_pkg::K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = sha1bsh_pkg::K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = sha1bsh_pkg::K2;
      end else begin
        f = b ^ c ^ d;
        k = sha1bsh_pkg::K3;
      end
      t = {a[26:0], a[31:27]} + f + e + k + w[i];
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    chain[0] = chain[0] + a;
    chain[1] = chain[1] + b;
    chain[2] = chain[2] + c;
    chain[3] = chain[3] + d;
    chain[4] = chain[4] + e;
  endfunction

  function automatic void sha1_absorb(logic [7:0] v);
    blk_mem[fill_idx] = v;
    fill_idx = fill_idx + 6'd1;
    byte_cnt = byte_cnt + 29'd1;
    if (fill_idx == 6'd0) begin
      sha1_compress();
    end
  endfunction

  function automatic void sha1_restart();
    chain = sha1bsh_pkg::CHAIN_INIT;
    fill_idx = '0;
    byte_cnt = '0;
  endfunction

  function automatic void sha1_take_word(in_word_t iw);
    logic [31:0] bits;
    digest_exp_t de;
    int i;
    case (iw.mode)
      sha1bsh_pkg::MODE_DATA: begin
        sha1_absorb(iw.data);
      end
      sha1bsh_pkg::MODE_RESTART: begin
        sha1_restart();
      end
      sha1bsh_pkg::MODE_FINISH: begin
        bits = {byte_cnt, 3'b000};
        sha1_absorb(sha1bsh_pkg::PAD_BYTE);
        while (fill_idx != sha1bsh_pkg::LEN_OFFSET) sha1_absorb(8'h00);
        for (i = 0; i < 4; i++) sha1_absorb(8'h00);
        sha1_absorb(bits[31:24]);
        sha1_absorb(bits[23:16]);
        sha1_absorb(bits[15:8]);
        sha1_absorb(bits[7:0]);
        for (i = 0; i < 5; i++) begin
          de.word = chain[i];
          de.last = (i == 4);
          digest_q.push_back(de);
        end
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void push_word(sha1bsh_pkg::mode_e m, logic [7:0] b);
    in_word_t iw;
    iw.mode = m;
    iw.data = b;
    word_q.push_back(iw);
  endfunction

  task automatic queue_directed();
    int i;
    push_word(sha1bsh_pkg::MODE_FINISH, 8'h00);
    push_word(sha1bsh_pkg::MODE_DATA, 8'h00);
    push_word(sha1bsh_pkg::MODE_DATA, 8'hFF);
    push_word(sha1bsh_pkg::MODE_UNUSED, 8'hA5);
    push_word(sha1bsh_pkg::MODE_DATA, 8'h61);
    push_word(sha1bsh_pkg::MODE_FINISH, 8'hFF);
    push_word(sha1bsh_pkg::MODE_RESTART, 8'h00);
    push_word(sha1bsh_pkg::MODE_DATA, 8'h61);
    push_word(sha1bsh_pkg::MODE_DATA, 8'h62);
    push_word(sha1bsh_pkg::MODE_DATA, 8'h63);
    push_word(sha1bsh_pkg::MODE_FINISH, 8'h00);
    push_word(sha1bsh_pkg::MODE_FINISH, 8'h00);
    push_word(sha1bsh_pkg::MODE_RESTART, 8'hFF);
    push_word(sha1bsh_pkg::MODE_FINISH, 8'h00);
    push_word(sha1bsh_pkg::MODE_DATA, 8'h55);
    push_word(sha1bsh_pkg::MODE_RESTART, 8'h00);
    push_word(sha1bsh_pkg::MODE_DATA, 8'hAA);
    push_word(sha1bsh_pkg::MODE_UNUSED, 8'h5A);
    push_word(sha1bsh_pkg::MODE_FINISH, 8'h00);
    // full block from data words, then a tail that needs two pad blocks
    push_word(sha1bsh_pkg::MODE_RESTART, 8'h00);
    for (i = 0; i < 120; i++) begin
      push_word(sha1bsh_pkg::MODE_DATA, 8'($urandom_range(255)));
    end
    push_word(sha1bsh_pkg::MODE_FINISH, 8'h00);
  endtask

  task automatic queue_random(int unsigned max_words);
    int unsigned words, len, r, i;
    words = 0;
    while (words < max_words) begin
      if ($urandom_range(1) == 1) begin
        push_word(sha1bsh_pkg::MODE_RESTART, 8'($urandom_range(255)));
        words++;
      end
      r = $urandom_range(99);
      if (r < 65) begin
        len = $urandom_range(8);
      end else if (r < 90) begin
        len = $urandom_range(68, 52);
      end else begin
        len = $urandom_range(130, 118);
      end
      if (words + len + 1 > max_words) begin
        len = (max_words > words + 1) ? max_words - words - 1 : 0;
      end
      for (i = 0; i < len; i++) begin
        r = $urandom_range(99);
        if (r < 4) begin
          push_word(sha1bsh_pkg::MODE_UNUSED, 8'($urandom_range(255)));
          words++;
        end else if (r < 6) begin
          push_word(sha1bsh_pkg::MODE_RESTART, 8'($urandom_range(255)));
          words++;
        end
        push_word(sha1bsh_pkg::MODE_DATA, 8'($urandom_range(255)));
        words++;
      end
      if ($urandom_range(9) != 0 || words + 1 >= max_words) begin
        push_word(sha1bsh_pkg::MODE_FINISH, 8'($urandom_range(255)));
        words++;
      end
    end
  endtask

  task automatic drain();
    while (word_q.size() != 0 || in_valid_i || digest_q.size() != 0) @(negedge clk_i);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      mode_i <= sha1bsh_pkg::MODE_DATA;
      data_byte_i <= 8'h00;
      sha1_restart();
    end else begin
      if (in_valid_i && in_ready_o) begin
        next_word.mode = sha1bsh_pkg::mode_e'(mode_i);
        next_word.data = data_byte_i;
        sha1_take_word(next_word);
      end
      if (!in_valid_i || in_ready_o) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = word_q.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= next_word.mode;
          data_byte_i <= next_word.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // sink with one long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (pressure_on && !hold_done && out_valid_o) begin
      hold_left <= 400;
      hold_done <= 1'b1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_q.size() == 0) begin
        $display("%0t: digest_word expected none actual %h", $time, digest_word_o);
        mismatch_cnt++;
      end else begin
        got_exp = digest_q.pop_front();
        if (digest_word_o !== got_exp.word) begin
          $display("%0t: digest_word expected %h actual %h", $time, got_exp.word,
                   digest_word_o);
          mismatch_cnt++;
        end
        if (last_word_o !== got_exp.last) begin
          $display("%0t: last_word expected %b actual %b", $time, got_exp.last,
                   last_word_o);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    pressure_on = 1'b1;
    queue_directed();
    queue_random(8);
    drain();
    pressure_on = 1'b0;
    send_idle_pct = 70;
    queue_random(8);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 70;
    queue_random(8);
    drain();
    send_idle_pct = 18;
    recv_stall_pct = 18;
    queue_random(8);
    drain();
    repeat (200) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
